// ===== hdl/jsu_pkg.sv =====
package jsu_pkg;

  localparam int WORD_BITS = 32;
  localparam int IN_BITS   = 32;
  localparam int CNT_BITS  = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

  localparam logic [2:0] MOD8_NEG_A = 3'd3;
  localparam logic [2:0] MOD8_NEG_B = 3'd5;
  localparam logic [1:0] MOD4_THREE = 2'd3;

  localparam logic [1:0] SYM_ZERO = 2'b00;
  localparam logic [1:0] SYM_POS  = 2'b01;
  localparam logic [1:0] SYM_NEG  = 2'b11;

  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_INVALID = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MOD,
    S_TEST,
    S_STRIP,
    S_REC,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_SIGN,
    RES_ZERO,
    RES_INVALID
  } res_kind_t;

  typedef struct packed {
    logic      load;
    logic      mod_step;
    logic      strip;
    logic      rec;
    logic      res_load;
    res_kind_t res_kind;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic invalid;
    logic mod_last;
    logic a_zero;
    logic a_even;
    logic a_next_odd;
    logic a_one;
  } dp_status_t;

  function automatic logic [WORD_BITS-1:0] fit_word(input logic [IN_BITS-1:0] x);
    logic [IN_BITS+WORD_BITS-1:0] wide;
    wide = {{WORD_BITS{1'b0}}, x};
    return wide[WORD_BITS-1:0];
  endfunction

endpackage

// ===== hdl/jsu_datapath.sv =====
module jsu_datapath (
  input  logic                         clk,
  input  jsu_pkg::dp_cmd_t             cmd,
  input  logic [jsu_pkg::IN_BITS-1:0]  numerator_value,
  input  logic [jsu_pkg::IN_BITS-1:0]  modulus_value,
  output jsu_pkg::dp_status_t          stat,
  output logic signed [1:0]            symbol,
  output logic                         status
);

  localparam int W = jsu_pkg::WORD_BITS;

  logic [W-1:0]                 a;
  logic [W-1:0]                 m;
  logic [W-1:0]                 rem;
  logic [jsu_pkg::CNT_BITS-1:0] cnt;
  logic                         neg;
  logic [1:0]                   res_symbol;
  logic                         res_status;

  logic [W-1:0] in_a;
  logic [W-1:0] in_m;
  logic [W:0]   trial;
  logic [W:0]   m_ext;
  logic [W:0]   diff;
  logic [W-1:0] rem_next;
  logic         m8_neg;
  logic         recip_neg;

  assign in_a  = jsu_pkg::fit_word(numerator_value);
  assign in_m  = jsu_pkg::fit_word(modulus_value);
  assign trial = {rem, a[W-1]};
  assign m_ext = {1'b0, m};
  assign diff  = trial - m_ext;
  assign rem_next = (trial >= m_ext) ? diff[W-1:0] : trial[W-1:0];

  assign m8_neg    = (m[2:0] == jsu_pkg::MOD8_NEG_A) || (m[2:0] == jsu_pkg::MOD8_NEG_B);
  assign recip_neg = (a[1:0] == jsu_pkg::MOD4_THREE) && (m[1:0] == jsu_pkg::MOD4_THREE);

  assign stat.invalid    = (in_m < W'(3)) || !in_m[0];
  assign stat.mod_last   = (cnt == jsu_pkg::CNT_BITS'(W - 1));
  assign stat.a_zero     = (a == '0);
  assign stat.a_even     = !a[0];
  assign stat.a_next_odd = a[1];
  assign stat.a_one      = (a == W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= in_a;
      m   <= in_m;
      rem <= '0;
      cnt <= '0;
      neg <= 1'b0;
    end else if (cmd.mod_step) begin
      if (stat.mod_last) begin
        a   <= rem_next;
        rem <= '0;
        cnt <= '0;
      end else begin
        a   <= {a[W-2:0], 1'b0};
        rem <= rem_next;
        cnt <= cnt + 1'b1;
      end
    end else if (cmd.strip) begin
      a <= {1'b0, a[W-1:1]};
      if (m8_neg) begin
        neg <= !neg;
      end
    end else if (cmd.rec) begin
      a <= m;
      m <= a;
      if (recip_neg) begin
        neg <= !neg;
      end
    end
    if (cmd.res_load) begin
      unique case (cmd.res_kind)
        jsu_pkg::RES_SIGN: begin
          res_symbol <= neg ? jsu_pkg::SYM_NEG : jsu_pkg::SYM_POS;
          res_status <= jsu_pkg::STAT_OK;
        end
        jsu_pkg::RES_ZERO: begin
          res_symbol <= jsu_pkg::SYM_ZERO;
          res_status <= jsu_pkg::STAT_OK;
        end
        default: begin
          res_symbol <= jsu_pkg::SYM_ZERO;
          res_status <= jsu_pkg::STAT_INVALID;
        end
      endcase
    end
    if (cmd.out_load) begin
      symbol <= res_symbol;
      status <= res_status;
    end
  end

endmodule

// ===== hdl/jsu_ctrl.sv =====
module jsu_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  jsu_pkg::dp_status_t stat,
  output jsu_pkg::dp_cmd_t    cmd
);

  jsu_pkg::state_t state;
  jsu_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != jsu_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      jsu_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = stat.invalid ? jsu_pkg::S_DONE : jsu_pkg::S_MOD;
        end
      end
      jsu_pkg::S_MOD: begin
        if (stat.mod_last) begin
          state_next = jsu_pkg::S_TEST;
        end
      end
      jsu_pkg::S_TEST: begin
        priority if (stat.a_zero) begin
          state_next = jsu_pkg::S_DONE;
        end else if (stat.a_even) begin
          state_next = jsu_pkg::S_STRIP;
        end else begin
          state_next = jsu_pkg::S_REC;
        end
      end
      jsu_pkg::S_STRIP: begin
        if (stat.a_next_odd) begin
          state_next = jsu_pkg::S_REC;
        end
      end
      jsu_pkg::S_REC: begin
        state_next = stat.a_one ? jsu_pkg::S_DONE : jsu_pkg::S_MOD;
      end
      jsu_pkg::S_DONE: begin
        if (out_free) begin
          state_next = jsu_pkg::S_IDLE;
        end
      end
      default: state_next = jsu_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_kind = jsu_pkg::RES_SIGN;
    unique case (state)
      jsu_pkg::S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid && stat.invalid) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = jsu_pkg::RES_INVALID;
        end
      end
      jsu_pkg::S_MOD: cmd.mod_step = 1'b1;
      jsu_pkg::S_TEST: begin
        if (stat.a_zero) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = jsu_pkg::RES_ZERO;
        end
      end
      jsu_pkg::S_STRIP: cmd.strip = 1'b1;
      jsu_pkg::S_REC: begin
        if (stat.a_one) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = jsu_pkg::RES_SIGN;
        end else begin
          cmd.rec = 1'b1;
        end
      end
      jsu_pkg::S_DONE: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= jsu_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_load || (out_valid && out_stall);
    end
  end

endmodule

// ===== hdl/jacobi_symbol_unit_top.sv =====
// Jacobi symbol (a/m) of an unsigned 32-bit a and an odd modulus m >= 3, returned as
// -1/0/+1 in two's complement; an even modulus or one below 3 gives status 1 and symbol 0.
// One transaction at a time. Each reduction round does the bit-serial a mod m over
// WORD_BITS steps, then a test, a strip step for each factor of two and a reciprocity step,
// except that a round whose remainder is zero (common factor) ends after its test;
// the accept step comes before the rounds and the output step after them. The round
// count is that of the Euclid-like reduction. An invalid modulus skips the rounds and
// goes from the accept step straight to the output step. The unit waits in its output step
// while the previous result is still stalled. A new transaction is taken once the result has moved
// to the output register, even if that result is still stalled.
module jacobi_symbol_unit_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [jsu_pkg::IN_BITS-1:0] numerator_value,
  input  logic [jsu_pkg::IN_BITS-1:0] modulus_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [1:0]           symbol,
  output logic                        status
);

  jsu_pkg::dp_cmd_t    cmd;
  jsu_pkg::dp_status_t stat;

  jsu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  jsu_datapath u_dp (
    .clk             (clk),
    .cmd             (cmd),
    .numerator_value (numerator_value),
    .modulus_value   (modulus_value),
    .stat            (stat),
    .symbol          (symbol),
    .status          (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("unit not busy after accepting a transaction");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (symbol == jsu_pkg::SYM_ZERO))
    else $error("invalid modulus with nonzero symbol");

  a_symbol_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (symbol != 2'b10))
    else $error("illegal symbol code");

  a_out_only_when_idle_next: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid) && !$past(rst)) |-> !in_stall)
    else $error("result presented while unit still busy");

endmodule
